>>> hdl/vmrd_pkg.sv
// ============================================================================
// vmrd_pkg
// Shared constants and types of the viewport mask run decoder.
// ============================================================================
`default_nettype none

package vmrd_pkg;

    // Largest image dimension; rows and columns wrap modulo this.
    localparam int MAX_DIM     = 4096;
    // Length added by each zero prefix byte.
    localparam int LENGTH_STEP = 256;
    // Depth of the command queue between front and back; a power of two.
    localparam int QUEUE_DEPTH = 4;

    localparam int DIM_W = $clog2(MAX_DIM + 1);            // sizes, counts
    localparam int POS_W = $clog2(MAX_DIM);                // positions
    localparam int LEN_W = $clog2(256 + 2 * LENGTH_STEP);  // decoded length
    localparam int CMP_W = (DIM_W > LEN_W) ? DIM_W : LEN_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_COLUMNS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT_ROWS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLUMNS    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS       = 3'd5;

    typedef struct packed {
        logic [POS_W-1:0] viewport_left;
        logic [POS_W-1:0] viewport_top;
        logic [DIM_W-1:0] viewport_columns;
        logic [DIM_W-1:0] viewport_rows;
        logic [DIM_W-1:0] image_columns;
        logic [DIM_W-1:0] image_rows;
    } vmrd_cfg_t;

    // Command from front to back; positions are relative to the viewport.
    typedef struct packed {
        logic             present;
        logic [POS_W-1:0] row_offset;
        logic [POS_W-1:0] col_offset;
        logic [DIM_W-1:0] length;
        logic             transparent;
        logic             done;
        logic             status;
        logic [DIM_W-1:0] completed;
    } vmrd_cmd_t;

endpackage

`default_nettype wire

>>> hdl/vmrd_queue.sv
// ============================================================================
// vmrd_queue
// Short register queue carrying commands from the front to the back.
// ============================================================================
`default_nettype none

module vmrd_queue
    import vmrd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      wr,
    input  wire vmrd_cmd_t wdata,
    input  wire logic      rd,
    output vmrd_cmd_t      rdata,
    output logic           head_valid,
    output logic           full
);

    vmrd_cmd_t        slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign rdata      = slots_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full))
        else $error("write into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd && !head_valid))
        else $error("read from empty queue");
`endif

endmodule

`default_nettype wire

>>> hdl/vmrd_front.sv
// ============================================================================
// vmrd_front
// Byte parser: tracks row, column and prefix state, clips each run.
// ============================================================================
`default_nettype none

module vmrd_front
    import vmrd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire vmrd_cfg_t  cfg,
    input  wire logic       accept,
    input  wire logic [7:0] mask_byte,
    input  wire logic       final_byte,
    output logic            cmd_wr,
    output vmrd_cmd_t       cmd
);

    typedef enum logic [1:0] {
        PH_POLARITY,
        PH_LENGTH,
        PH_ONE_ZERO,
        PH_TWO_ZERO
    } phase_t;

    phase_t           phase_reg,    phase_next;
    logic [DIM_W-1:0] row_reg,      row_next;
    logic [DIM_W-1:0] col_reg,      col_next;
    logic [7:0]       pol_reg,      pol_next;
    logic             halted_reg,   halted_next;
    logic             vp_err_reg,   vp_err_next;

    logic             vp_ok;
    logic             got;
    logic [LEN_W-1:0] len;
    logic [DIM_W-1:0] room;
    logic [DIM_W-1:0] vis;

    // Viewport check, all on register values.
    always_comb
    begin
        vp_ok = 1'b1;
        if (cfg.viewport_columns == '0 || cfg.viewport_rows == '0)
            vp_ok = 1'b0;
        if (cfg.image_columns == '0 || cfg.image_rows == '0)
            vp_ok = 1'b0;
        if (cfg.image_columns > DIM_W'(MAX_DIM) || cfg.image_rows > DIM_W'(MAX_DIM))
            vp_ok = 1'b0;
        if (cfg.viewport_columns > cfg.image_columns
            || cfg.viewport_rows > cfg.image_rows)
            vp_ok = 1'b0;
        else
        begin
            if (DIM_W'(cfg.viewport_left) > cfg.image_columns - cfg.viewport_columns)
                vp_ok = 1'b0;
            if (DIM_W'(cfg.viewport_top) > cfg.image_rows - cfg.viewport_rows)
                vp_ok = 1'b0;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        pol_next    = pol_reg;
        halted_next = halted_reg;
        vp_err_next = vp_err_reg;
        got         = 1'b0;
        len         = '0;
        cmd         = '0;

        room = (cfg.viewport_columns > col_reg) ? cfg.viewport_columns - col_reg : '0;

        if (!vp_ok)
        begin
            vp_err_next = 1'b1;
        end
        else if (!halted_reg && !vp_err_reg)
        begin
            case (phase_reg)
                PH_POLARITY:
                begin
                    if (row_reg >= cfg.viewport_rows)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        pol_next   = mask_byte;
                        col_next   = '0;
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH:
                begin
                    if (mask_byte != 8'd0)
                    begin
                        len = LEN_W'(mask_byte);
                        got = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ONE_ZERO;
                    end
                end
                PH_ONE_ZERO:
                begin
                    if (mask_byte != 8'd0)
                    begin
                        len = LEN_W'(mask_byte) + LEN_W'(LENGTH_STEP);
                        got = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_TWO_ZERO;
                    end
                end
                PH_TWO_ZERO:
                begin
                    len = LEN_W'(mask_byte) + LEN_W'(2 * LENGTH_STEP);
                    got = 1'b1;
                end
                default:
                begin
                    phase_next = PH_POLARITY;
                end
            endcase
        end

        // Clip against the room left in the row.
        vis = (CMP_W'(len) < CMP_W'(room)) ? DIM_W'(len) : room;

        if (got)
        begin
            cmd.present     = 1'b1;
            cmd.row_offset  = row_reg[POS_W-1:0];
            cmd.col_offset  = col_reg[POS_W-1:0];
            cmd.length      = vis;
            cmd.transparent = ~pol_reg[7];
            col_next        = col_reg + vis;
            pol_next        = 8'd0 - pol_reg;
            phase_next      = PH_LENGTH;
            if (col_next >= cfg.viewport_columns)
            begin
                row_next   = row_reg + DIM_W'(1);
                phase_next = PH_POLARITY;
                if (row_next >= cfg.viewport_rows)
                    halted_next = 1'b1;
            end
        end

        if (final_byte)
        begin
            cmd.done      = 1'b1;
            cmd.status    = vp_err_next;
            cmd.completed = vp_err_next ? '0 : row_next;
            phase_next    = PH_POLARITY;
            row_next      = '0;
            col_next      = '0;
            pol_next      = '0;
            halted_next   = 1'b0;
            vp_err_next   = 1'b0;
        end
    end

    assign cmd_wr = accept && (got || final_byte);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_POLARITY;
            row_reg    <= '0;
            col_reg    <= '0;
            pol_reg    <= '0;
            halted_reg <= 1'b0;
            vp_err_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            pol_reg    <= pol_next;
            halted_reg <= halted_next;
            vp_err_reg <= vp_err_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_halt_at_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> phase_reg == PH_POLARITY)
        else $error("halted inside a row");
    a_error_no_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_wr && cmd.status |-> !cmd.present && cmd.completed == '0)
        else $error("run or row count issued with viewport error");
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        vp_err_reg |-> !got)
        else $error("decode after viewport error");
`endif

endmodule

`default_nettype wire

>>> hdl/vmrd_back.sv
// ============================================================================
// vmrd_back
// Output stage: places runs in image coordinates and holds the result item.
// ============================================================================
`default_nettype none

module vmrd_back
    import vmrd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vmrd_cfg_t         cfg,
    input  wire vmrd_cmd_t         head,
    input  wire logic              head_valid,
    output logic                   head_rd,
    input  wire logic              pop,
    output logic                   empty,
    output logic                   run_present,
    output logic [POS_W-1:0]       run_row,
    output logic [POS_W-1:0]       run_start,
    output logic [DIM_W-1:0]       run_length,
    output logic                   make_transparent,
    output logic                   stream_done,
    output logic                   status,
    output logic [DIM_W-1:0]       completed_rows
);

    logic             valid_reg;
    logic             present_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] start_reg;
    logic [DIM_W-1:0] length_reg;
    logic             transp_reg;
    logic             done_reg;
    logic             status_reg;
    logic [DIM_W-1:0] completed_reg;

    assign head_rd = head_valid && (!valid_reg || pop);
    assign empty   = !valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (head_rd)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_rd)
        begin
            present_reg   <= head.present;
            row_reg       <= head.present ? cfg.viewport_top + head.row_offset : '0;
            start_reg     <= head.present ? cfg.viewport_left + head.col_offset : '0;
            length_reg    <= head.length;
            transp_reg    <= head.transparent;
            done_reg      <= head.done;
            status_reg    <= head.status;
            completed_reg <= head.completed;
        end
    end

    assign run_present      = present_reg;
    assign run_row          = row_reg;
    assign run_start        = start_reg;
    assign run_length       = length_reg;
    assign make_transparent = transp_reg;
    assign stream_done      = done_reg;
    assign status           = status_reg;
    assign completed_rows   = completed_reg;

endmodule

`default_nettype wire

>>> hdl/viewport_mask_run_decoder.sv
// ============================================================================
// viewport_mask_run_decoder
// Run-length mask decoder producing clipped run items for a viewport.
// ============================================================================
// Takes one mask byte per clock while full is low and gives at most one
// result item per byte: a clipped run and/or, for the byte marked final, the
// end-of-stream report. Sustained rate is one byte per cycle while full stays
// low; the front stage parser updates its row/column state and clips the run
// in the same cycle as the byte is accepted. A result passes through the
// command queue and then the output register. A four-entry command queue
// between parser and output stage absorbs pop stalls, so full only rises once
// it and the output register are occupied. Configuration registers are written
// through cfg_write, cfg_index and cfg_data, take effect at once and should only
// be changed with the block idle; indices above 5 are ignored. There is no
// clearing pass after reset.
// ============================================================================
`default_nettype none

module viewport_mask_run_decoder
    import vmrd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration write port
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    // byte input, queue style
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [7:0]           mask_byte,
    input  wire logic                 final_byte,
    // result output, queue style
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      run_present,
    output logic [POS_W-1:0]          run_row,
    output logic [POS_W-1:0]          run_start,
    output logic [DIM_W-1:0]          run_length,
    output logic                      make_transparent,
    output logic                      stream_done,
    output logic                      status,
    output logic [DIM_W-1:0]          completed_rows
);

    vmrd_cfg_t cfg_reg;
    vmrd_cmd_t cmd_in;
    vmrd_cmd_t cmd_head;
    logic      cmd_wr;
    logic      head_valid;
    logic      head_rd;
    logic      accept;

    // Register file; all zero out of reset, values masked to width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VIEWPORT_LEFT:    cfg_reg.viewport_left    <= cfg_data[POS_W-1:0];
                CFG_VIEWPORT_TOP:     cfg_reg.viewport_top     <= cfg_data[POS_W-1:0];
                CFG_VIEWPORT_COLUMNS: cfg_reg.viewport_columns <= cfg_data;
                CFG_VIEWPORT_ROWS:    cfg_reg.viewport_rows    <= cfg_data;
                CFG_IMAGE_COLUMNS:    cfg_reg.image_columns    <= cfg_data;
                CFG_IMAGE_ROWS:       cfg_reg.image_rows       <= cfg_data;
                default:              ;
            endcase
        end
    end

    // A byte is taken whenever push is high and the command queue has room.
    assign accept = push && !full;

    vmrd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .accept     (accept),
        .mask_byte  (mask_byte),
        .final_byte (final_byte),
        .cmd_wr     (cmd_wr),
        .cmd        (cmd_in)
    );

    vmrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (cmd_wr),
        .wdata      (cmd_in),
        .rd         (head_rd),
        .rdata      (cmd_head),
        .head_valid (head_valid),
        .full       (full)
    );

    vmrd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .head             (cmd_head),
        .head_valid       (head_valid),
        .head_rd          (head_rd),
        .pop              (pop),
        .empty            (empty),
        .run_present      (run_present),
        .run_row          (run_row),
        .run_start        (run_start),
        .run_length       (run_length),
        .make_transparent (make_transparent),
        .stream_done      (stream_done),
        .status           (status),
        .completed_rows   (completed_rows)
    );

endmodule

`default_nettype wire
